FILE: design/rotation_matrix_to_quaternion_assert.svh
// Assertion macros used by the rotation matrix to quaternion top level.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define RMQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rotation_matrix_to_quaternion: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rotation_matrix_to_quaternion: next-cycle check failed");

`endif

FILE: design/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion converter.
package rmq_pkg;

    // Four root lanes: w, x, y, z
    localparam int NUM_LANES = 4;
    localparam int LANE_W    = 0;
    localparam int LANE_X    = 1;
    localparam int LANE_Y    = 2;
    localparam int LANE_Z    = 3;

    // Field widths
    localparam int IN_W      = 16;
    localparam int W_W       = 15;
    localparam int S_W       = 16;

    // Largest magnitude the output fields carry (1.0 in Q1.14)
    localparam int FIELD_CAP = 16384;

    // Control that travels with each item down the chain
    typedef struct packed {
        logic                 valid;
        logic [NUM_LANES-1:0] neg;
    } t_ctl;

endpackage

FILE: design/rmq_prep.sv
// Input stage: diagonal sums, clamping, root arguments and sign flags.
module rmq_prep #(
    parameter int FRAC_BITS = 14,
    parameter int SUM_W     = 20,
    parameter int ARG_W     = 34
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_take,
    input  logic signed [rmq_pkg::IN_W-1:0]               i_r00,
    input  logic signed [rmq_pkg::IN_W-1:0]               i_r01,
    input  logic signed [rmq_pkg::IN_W-1:0]               i_r02,
    input  logic signed [rmq_pkg::IN_W-1:0]               i_r10,
    input  logic signed [rmq_pkg::IN_W-1:0]               i_r11,
    input  logic signed [rmq_pkg::IN_W-1:0]               i_r12,
    input  logic signed [rmq_pkg::IN_W-1:0]               i_r20,
    input  logic signed [rmq_pkg::IN_W-1:0]               i_r21,
    input  logic signed [rmq_pkg::IN_W-1:0]               i_r22,
    output rmq_pkg::t_ctl                                 o_ctl,
    output logic [rmq_pkg::NUM_LANES-1:0][ARG_W-1:0]      o_rad
);

    localparam int EXT_W = SUM_W - rmq_pkg::IN_W;

    logic signed [SUM_W-1:0]                        one_s;
    logic signed [SUM_W-1:0]                        e00;
    logic signed [SUM_W-1:0]                        e11;
    logic signed [SUM_W-1:0]                        e22;
    logic signed [rmq_pkg::NUM_LANES-1:0][SUM_W-1:0] sum;
    logic signed [rmq_pkg::IN_W:0]                  dx;
    logic signed [rmq_pkg::IN_W:0]                  dy;
    logic signed [rmq_pkg::IN_W:0]                  dz;

    rmq_pkg::t_ctl                                  r_ctl;
    rmq_pkg::t_ctl                                  n_ctl;
    logic [rmq_pkg::NUM_LANES-1:0][ARG_W-1:0]       r_rad;
    logic [rmq_pkg::NUM_LANES-1:0][ARG_W-1:0]       n_rad;

    // Extend the diagonal and form the four signed sums
    assign one_s = SUM_W'(1) << FRAC_BITS;
    assign e00   = {{EXT_W{i_r00[rmq_pkg::IN_W-1]}}, i_r00};
    assign e11   = {{EXT_W{i_r11[rmq_pkg::IN_W-1]}}, i_r11};
    assign e22   = {{EXT_W{i_r22[rmq_pkg::IN_W-1]}}, i_r22};

    assign sum[rmq_pkg::LANE_W] = one_s + e00 + e11 + e22;
    assign sum[rmq_pkg::LANE_X] = one_s + e00 - e11 - e22;
    assign sum[rmq_pkg::LANE_Y] = one_s - e00 + e11 - e22;
    assign sum[rmq_pkg::LANE_Z] = one_s - e00 - e11 + e22;

    // Off-diagonal differences that pick the vector signs
    assign dx = {i_r21[rmq_pkg::IN_W-1], i_r21} - {i_r12[rmq_pkg::IN_W-1], i_r12};
    assign dy = {i_r02[rmq_pkg::IN_W-1], i_r02} - {i_r20[rmq_pkg::IN_W-1], i_r20};
    assign dz = {i_r10[rmq_pkg::IN_W-1], i_r10} - {i_r01[rmq_pkg::IN_W-1], i_r01};

    // Clamp negative sums to zero and scale up by the fraction bits
    always_comb begin
        for (int l = 0; l < rmq_pkg::NUM_LANES; l++) begin
            if (sum[l][SUM_W-1]) begin
                n_rad[l] = '0;
            end else begin
                n_rad[l] = ARG_W'({sum[l][SUM_W-2:0], {FRAC_BITS{1'b0}}});
            end
        end
        n_ctl.valid                  = i_take;
        n_ctl.neg[rmq_pkg::LANE_W]   = 1'b0;
        n_ctl.neg[rmq_pkg::LANE_X]   = dx[rmq_pkg::IN_W];
        n_ctl.neg[rmq_pkg::LANE_Y]   = dy[rmq_pkg::IN_W];
        n_ctl.neg[rmq_pkg::LANE_Z]   = dz[rmq_pkg::IN_W];
    end

    // Hold control under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // Capture the root arguments
    always_ff @(posedge i_clk) begin
        r_rad <= n_rad;
    end

    assign o_ctl = r_ctl;
    assign o_rad = r_rad;

endmodule

FILE: design/rmq_cell.sv
// One square-root cell: resolves one root bit in each of the four lanes.
module rmq_cell #(
    parameter int ROOT_W = 17,
    parameter int ARG_W  = 34
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  rmq_pkg::t_ctl                                  i_ctl,
    input  logic [rmq_pkg::NUM_LANES-1:0][ARG_W-1:0]       i_rad,
    input  logic [rmq_pkg::NUM_LANES-1:0][ROOT_W:0]        i_rem,
    input  logic [rmq_pkg::NUM_LANES-1:0][ROOT_W-1:0]      i_root,
    output rmq_pkg::t_ctl                                  o_ctl,
    output logic [rmq_pkg::NUM_LANES-1:0][ARG_W-1:0]       o_rad,
    output logic [rmq_pkg::NUM_LANES-1:0][ROOT_W:0]        o_rem,
    output logic [rmq_pkg::NUM_LANES-1:0][ROOT_W-1:0]      o_root
);

    localparam int RW = ROOT_W + 1;
    localparam int CW = ROOT_W + 3;

    logic [rmq_pkg::NUM_LANES-1:0][CW-1:0]      cand;
    logic [rmq_pkg::NUM_LANES-1:0][CW-1:0]      sub;
    logic [rmq_pkg::NUM_LANES-1:0][CW-1:0]      diff;

    rmq_pkg::t_ctl                              r_ctl;
    rmq_pkg::t_ctl                              n_ctl;
    logic [rmq_pkg::NUM_LANES-1:0][ARG_W-1:0]   r_rad;
    logic [rmq_pkg::NUM_LANES-1:0][ARG_W-1:0]   n_rad;
    logic [rmq_pkg::NUM_LANES-1:0][RW-1:0]      r_rem;
    logic [rmq_pkg::NUM_LANES-1:0][RW-1:0]      n_rem;
    logic [rmq_pkg::NUM_LANES-1:0][ROOT_W-1:0]  r_root;
    logic [rmq_pkg::NUM_LANES-1:0][ROOT_W-1:0]  n_root;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
        for (int l = 0; l < rmq_pkg::NUM_LANES; l++) begin
            cand[l] = {i_rem[l], i_rad[l][ARG_W-1 -: 2]};
            sub[l]  = {1'b0, i_root[l], 2'b01};
            diff[l] = cand[l] - sub[l];
            if (cand[l] >= sub[l]) begin
                n_rem[l]  = diff[l][RW-1:0];
                n_root[l] = {i_root[l][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[l]  = cand[l][RW-1:0];
                n_root[l] = {i_root[l][ROOT_W-2:0], 1'b0};
            end
            n_rad[l] = {i_rad[l][ARG_W-3:0], 2'b00};
        end
        n_ctl = i_ctl;
    end

    // Advance control to the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // Advance lane data to the neighbor
    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_ctl  = r_ctl;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

FILE: design/rotation_matrix_to_quaternion.sv
// Pipeline from start to o_valid: one input stage, one cell per root bit, one output stage;
// ROOT_W = (max(FRAC_BITS, 17) + 3 + FRAC_BITS) / 2.
// Throughput: one matrix per cycle; the cell chain takes a new item every cycle.
// busy is always low; each result shows for one cycle with o_valid and cannot be stalled.
// Reset (synchronous, active low) drops every item in flight; no clearing pass is needed.
// Top level: rotation matrix to quaternion converter built as a chain of root cells.
`include "rotation_matrix_to_quaternion_assert.svh"

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [rmq_pkg::IN_W-1:0]      i_r00,
    input  logic signed [rmq_pkg::IN_W-1:0]      i_r01,
    input  logic signed [rmq_pkg::IN_W-1:0]      i_r02,
    input  logic signed [rmq_pkg::IN_W-1:0]      i_r10,
    input  logic signed [rmq_pkg::IN_W-1:0]      i_r11,
    input  logic signed [rmq_pkg::IN_W-1:0]      i_r12,
    input  logic signed [rmq_pkg::IN_W-1:0]      i_r20,
    input  logic signed [rmq_pkg::IN_W-1:0]      i_r21,
    input  logic signed [rmq_pkg::IN_W-1:0]      i_r22,
    output logic                                 o_valid,
    output logic [rmq_pkg::W_W-1:0]              o_quat_w,
    output logic signed [rmq_pkg::S_W-1:0]       o_quat_x,
    output logic signed [rmq_pkg::S_W-1:0]       o_quat_y,
    output logic signed [rmq_pkg::S_W-1:0]       o_quat_z
);

    localparam int SUM_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
    localparam int ROOT_W = (SUM_W + FRAC_BITS) / 2;
    localparam int ARG_W  = 2 * ROOT_W;
    localparam int RW     = ROOT_W + 1;
    localparam int MAG_W  = (ROOT_W - 1 > rmq_pkg::W_W) ? (ROOT_W - 1) : rmq_pkg::W_W;
    localparam int CAP    = (FRAC_BITS < 14) ? (1 << FRAC_BITS) : rmq_pkg::FIELD_CAP;
    localparam int LAT    = ROOT_W + 2;

    rmq_pkg::t_ctl                                       ctl_c  [ROOT_W+1];
    logic [rmq_pkg::NUM_LANES-1:0][ARG_W-1:0]            rad_c  [ROOT_W+1];
    logic [rmq_pkg::NUM_LANES-1:0][RW-1:0]               rem_c  [ROOT_W+1];
    logic [rmq_pkg::NUM_LANES-1:0][ROOT_W-1:0]           root_c [ROOT_W+1];

    logic [rmq_pkg::NUM_LANES-1:0][MAG_W-1:0]            mag_ext;
    logic [rmq_pkg::NUM_LANES-1:0][rmq_pkg::W_W-1:0]     sat;
    logic [rmq_pkg::NUM_LANES-1:0][rmq_pkg::S_W-1:0]     sgn;

    logic                                                r_valid;
    logic                                                n_valid;
    logic [rmq_pkg::W_W-1:0]                             r_quat_w;
    logic [rmq_pkg::S_W-1:0]                             r_quat_x;
    logic [rmq_pkg::S_W-1:0]                             r_quat_y;
    logic [rmq_pkg::S_W-1:0]                             r_quat_z;

    // Always ready: a transfer happens on every start
    assign busy = 1'b0;

    rmq_prep #(
        .FRAC_BITS (FRAC_BITS),
        .SUM_W     (SUM_W),
        .ARG_W     (ARG_W)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (start & ~busy),
        .i_r00   (i_r00),
        .i_r01   (i_r01),
        .i_r02   (i_r02),
        .i_r10   (i_r10),
        .i_r11   (i_r11),
        .i_r12   (i_r12),
        .i_r20   (i_r20),
        .i_r21   (i_r21),
        .i_r22   (i_r22),
        .o_ctl   (ctl_c[0]),
        .o_rad   (rad_c[0])
    );

    // Start each root from zero
    assign rem_c[0]  = '0;
    assign root_c[0] = '0;

    // Chain of root cells, one per result bit
    for (genvar k = 0; k < ROOT_W; k++) begin : g_cell
        rmq_cell #(
            .ROOT_W (ROOT_W),
            .ARG_W  (ARG_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl_c[k]),
            .i_rad   (rad_c[k]),
            .i_rem   (rem_c[k]),
            .i_root  (root_c[k]),
            .o_ctl   (ctl_c[k+1]),
            .o_rad   (rad_c[k+1]),
            .o_rem   (rem_c[k+1]),
            .o_root  (root_c[k+1])
        );
    end

    // Halve the roots, saturate at CAP (one for FRAC_BITS up to 14), apply the vector signs
    always_comb begin
        for (int l = 0; l < rmq_pkg::NUM_LANES; l++) begin
            mag_ext[l] = MAG_W'(root_c[ROOT_W][l][ROOT_W-1:1]);
            if (mag_ext[l] > MAG_W'(CAP)) begin
                sat[l] = rmq_pkg::W_W'(CAP);
            end else begin
                sat[l] = mag_ext[l][rmq_pkg::W_W-1:0];
            end
            if (ctl_c[ROOT_W].neg[l]) begin
                sgn[l] = rmq_pkg::S_W'(0) - {1'b0, sat[l]};
            end else begin
                sgn[l] = {1'b0, sat[l]};
            end
        end
        n_valid = ctl_c[ROOT_W].valid;
    end

    // Hold the result strobe under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Register the result fields
    always_ff @(posedge i_clk) begin
        r_quat_w <= sat[rmq_pkg::LANE_W];
        r_quat_x <= sgn[rmq_pkg::LANE_X];
        r_quat_y <= sgn[rmq_pkg::LANE_Y];
        r_quat_z <= sgn[rmq_pkg::LANE_Z];
    end

    assign o_valid  = r_valid;
    assign o_quat_w = r_quat_w;
    assign o_quat_x = r_quat_x;
    assign o_quat_y = r_quat_y;
    assign o_quat_z = r_quat_z;

    // Remainder bound of the finished roots: rem <= 2 * root
    for (genvar l = 0; l < rmq_pkg::NUM_LANES; l++) begin : g_chk
        logic [RW-1:0] bound;
        assign bound = RW'(root_c[ROOT_W][l]) << 1;
        `RMQ_ASSERT_SAME(a_rem_bound, i_clk, i_rst_n, ctl_c[ROOT_W].valid, rem_c[ROOT_W][l] <= bound)
    end

    `RMQ_ASSERT_SAME(a_rad_drained, i_clk, i_rst_n, ctl_c[ROOT_W].valid, rad_c[ROOT_W] == '0)
    `RMQ_ASSERT_SAME(a_valid_from_start, i_clk, i_rst_n, o_valid, $past(start, LAT))
    `RMQ_ASSERT_NEXT(a_w_capped, i_clk, i_rst_n, n_valid, o_quat_w <= rmq_pkg::W_W'(CAP))
    `RMQ_ASSERT_SAME(a_x_capped, i_clk, i_rst_n, o_valid && !o_quat_x[rmq_pkg::S_W-1], o_quat_x <= rmq_pkg::S_W'(CAP))

endmodule
